### design/delay_adsr_envelope_generator_defines.svh
`ifndef DELAY_ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define DELAY_ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// Both macros expect signals named clk and rst in the scope that uses them.

// The consequent must hold in the same cycle as the antecedent.
`define DADSR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DADSR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dadsr_pkg.sv
`timescale 1ns / 1ps

package dadsr_pkg;

  localparam int DEF_VOICES   = 16;
  localparam int DEF_CHANNELS = 2;
  // Channels carried by one item.
  localparam int NCH          = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_SHAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS   = 3'd5;

  localparam logic [2:0] SEG_RELEASE = 3'd0;
  localparam logic [2:0] SEG_DELAY   = 3'd1;
  localparam logic [2:0] SEG_ATTACK  = 3'd2;
  localparam logic [2:0] SEG_DECAY   = 3'd3;
  localparam logic [2:0] SEG_SUSTAIN = 3'd4;

  localparam logic [15:0]        LEVEL_ONE = 16'h8000;
  localparam logic signed [15:0] GATE_HIGH = 16'sd5461;
  localparam logic signed [15:0] GATE_LOW  = 16'sd2730;
  localparam logic signed [15:0] RESET_ON  = 16'sd8192;
  localparam logic [23:0]        COUNT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [3:0]         voice;
    logic signed [15:0] gate_left;
    logic signed [15:0] gate_right;
    logic signed [15:0] reset_left;
    logic signed [15:0] reset_right;
    logic signed [15:0] audio_left;
    logic signed [15:0] audio_right;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         voice_out;
    logic [15:0]        level_left;
    logic [15:0]        level_right;
    logic signed [15:0] shaped_left;
    logic signed [15:0] shaped_right;
  } out_item_t;

  typedef struct packed {
    logic        linear_shape;
    logic [15:0] attack_step;
    logic [15:0] decay_step;
    logic [15:0] sustain_level;
    logic [15:0] release_step;
    logic [23:0] delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  seg;
    logic [15:0] level;
    logic [23:0] count;
    logic        held;
  } lane_state_t;

  typedef struct packed {
    logic load;
    logic adv;
  } pipe_ctl_t;

  typedef struct packed {
    logic [15:0]        level;
    logic signed [15:0] audio;
  } lane_res_t;

  function automatic logic [15:0] sat_one(input logic [15:0] v);
    return (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

endpackage

### design/dadsr_lane.sv
`timescale 1ns / 1ps

module dadsr_lane #(
  parameter int VOICES = dadsr_pkg::DEF_VOICES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dadsr_pkg::pipe_ctl_t   ctl,
  input  dadsr_pkg::cfg_t        cfg,
  input  logic [3:0]             voice,
  input  logic signed [15:0]     gate,
  input  logic signed [15:0]     clear,
  input  logic signed [15:0]     audio,
  output dadsr_pkg::lane_res_t   res
);

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

  dadsr_pkg::lane_state_t mem [VOICES];
  logic [VOICES-1:0]      vbit;

  logic [3:0]             voice_q;
  logic signed [15:0]     gate_q;
  logic signed [15:0]     clear_q;
  logic signed [15:0]     audio_q;
  dadsr_pkg::lane_state_t rd_q;

  logic                   lw_valid;
  logic [3:0]             lw_voice;
  dadsr_pkg::lane_state_t lw_state;

  logic                   in_range;
  dadsr_pkg::lane_state_t cur;
  dadsr_pkg::lane_state_t st;
  dadsr_pkg::lane_state_t nxt;
  logic [15:0]            step;
  logic [16:0]            mul_a;
  logic [15:0]            mul_r;
  logic [32:0]            prod;
  logic [16:0]            t;
  logic [15:0]            exp_dn;
  logic [15:0]            exp_up;
  logic [15:0]            lin_dn;
  logic [16:0]            lsum;
  logic [15:0]            lin_up;
  logic [15:0]            down;
  logic [15:0]            up;
  logic [23:0]            cnt_inc;

  assign in_range = (32'(voice_q) < 32'(VOICES));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      voice_q <= voice;
      gate_q  <= gate;
      clear_q <= clear;
      audio_q <= audio;
      rd_q    <= mem[AW'(voice)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && in_range) begin
      mem[AW'(voice_q)] <= nxt;
    end
  end

  // The last write is kept aside: the memory read for the following item
  // was taken before that write landed.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit     <= '0;
      lw_valid <= 1'b0;
    end else if (ctl.adv && in_range) begin
      vbit[AW'(voice_q)] <= 1'b1;
      lw_valid           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && in_range) begin
      lw_voice <= voice_q;
      lw_state <= nxt;
    end
  end

  always_comb begin
    if (lw_valid && (lw_voice == voice_q)) begin
      cur = lw_state;
    end else if (vbit[AW'(voice_q)]) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end

    st = cur;
    if (clear_q >= dadsr_pkg::RESET_ON) begin
      st = '0;
    end
    if (gate_q > dadsr_pkg::GATE_HIGH) begin
      if (!st.held) begin
        st.count = '0;
        st.seg   = dadsr_pkg::SEG_DELAY;
      end
      st.held = 1'b1;
    end else if (gate_q <= dadsr_pkg::GATE_LOW) begin
      if (st.held) begin
        st.seg = dadsr_pkg::SEG_RELEASE;
      end
      st.held = 1'b0;
    end

    unique case (st.seg)
      dadsr_pkg::SEG_ATTACK: step = cfg.attack_step;
      dadsr_pkg::SEG_DECAY:  step = cfg.decay_step;
      default:               step = cfg.release_step;
    endcase

    // One multiplier serves both directions: falling segments scale
    // (level + 1.0), attack scales the distance (2.0 - level).
    if (st.seg == dadsr_pkg::SEG_ATTACK) begin
      mul_a = 17'h10000 - {1'b0, st.level};
    end else begin
      mul_a = {1'b0, st.level} + 17'h08000;
    end
    mul_r = dadsr_pkg::LEVEL_ONE - step;
    prod  = {16'b0, mul_a} * {17'b0, mul_r};
    t     = prod[31:15];

    exp_dn = (t > 17'h08000) ? 16'(t - 17'h08000) : '0;
    exp_up = (t < 17'h08000) ? dadsr_pkg::LEVEL_ONE : 16'(17'h10000 - t);
    lin_dn = (st.level > step) ? (st.level - step) : '0;
    lsum   = {1'b0, st.level} + {1'b0, step};
    lin_up = (lsum > 17'h08000) ? dadsr_pkg::LEVEL_ONE : lsum[15:0];
    down   = cfg.linear_shape ? lin_dn : exp_dn;
    up     = cfg.linear_shape ? lin_up : exp_up;

    cnt_inc = (st.count == dadsr_pkg::COUNT_MAX) ? st.count : (st.count + 24'd1);

    nxt = st;
    unique case (st.seg)
      dadsr_pkg::SEG_DELAY: begin
        nxt.level = down;
        nxt.count = cnt_inc;
        if (cnt_inc >= cfg.delay_ticks) begin
          nxt.seg = dadsr_pkg::SEG_ATTACK;
        end
      end
      dadsr_pkg::SEG_ATTACK: begin
        nxt.level = up;
        if (up >= dadsr_pkg::LEVEL_ONE) begin
          nxt.seg = dadsr_pkg::SEG_DECAY;
        end
      end
      dadsr_pkg::SEG_DECAY: begin
        // The exponential clamp to the sustain level lands in the same arm.
        if (down <= cfg.sustain_level) begin
          nxt.level = cfg.sustain_level;
          nxt.seg   = dadsr_pkg::SEG_SUSTAIN;
        end else begin
          nxt.level = down;
        end
      end
      dadsr_pkg::SEG_SUSTAIN: begin
        nxt.level = st.level;
      end
      default: begin
        nxt.level = down;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      res.level <= in_range ? nxt.level : '0;
      res.audio <= audio_q;
    end
  end

endmodule

### design/dadsr_merge.sv
`timescale 1ns / 1ps

module dadsr_merge (
  input  logic                                      clk,
  input  logic                                      load,
  input  logic [3:0]                                voice,
  input  dadsr_pkg::lane_res_t [dadsr_pkg::NCH-1:0] lanes,
  output dadsr_pkg::out_item_t                      result
);

  logic signed [32:0] prod [dadsr_pkg::NCH];

  // Arithmetic shift by 15 floors toward minus infinity, as required.
  always_comb begin
    for (int c = 0; c < dadsr_pkg::NCH; c++) begin
      prod[c] = 33'(lanes[c].audio) * 33'($signed({1'b0, lanes[c].level}));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.voice_out    <= voice;
      result.level_left   <= lanes[0].level;
      result.level_right  <= lanes[1].level;
      result.shaped_left  <= prod[0][30:15];
      result.shaped_right <= prod[1][30:15];
    end
  end

endmodule

### design/delay_adsr_envelope_generator.sv
// Pipeline of three registers: state read, envelope update, output.
// Throughput: one item per cycle unless result_ready back-pressure stalls the pipeline,
// with one state memory read per lane per item; a back-to-back item for the same voice
// takes the last write from a bypass register. Reset (rst, synchronous) clears all
// per-voice state at once through valid bits, empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`include "delay_adsr_envelope_generator_defines.svh"

module delay_adsr_envelope_generator #(
  parameter int VOICES   = dadsr_pkg::DEF_VOICES,
  parameter int CHANNELS = dadsr_pkg::DEF_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  dadsr_pkg::in_item_t                   item,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output dadsr_pkg::out_item_t                  result,
  input  logic                                  cfg_write,
  input  logic [dadsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dadsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int LANES = (CHANNELS < dadsr_pkg::NCH) ? CHANNELS : dadsr_pkg::NCH;

  dadsr_pkg::cfg_t      cfg;
  dadsr_pkg::pipe_ctl_t ctl;

  logic s1_valid;
  logic s2_valid;
  logic s1_adv;
  logic s2_adv;
  logic load;

  logic [3:0] s1_voice;
  logic [3:0] s2_voice;

  logic signed [15:0] gate_ch  [dadsr_pkg::NCH];
  logic signed [15:0] clear_ch [dadsr_pkg::NCH];
  logic signed [15:0] audio_ch [dadsr_pkg::NCH];

  dadsr_pkg::lane_res_t [dadsr_pkg::NCH-1:0] lane_res;

  assign s2_adv     = s2_valid && (!result_valid || result_ready);
  assign s1_adv     = s1_valid && (!s2_valid || s2_adv);
  assign item_ready = !s1_valid || s1_adv;
  assign load       = item_valid && item_ready;
  assign ctl        = '{load: load, adv: s1_adv};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_voice <= item.voice;
    end
    if (s1_adv) begin
      s2_voice <= s1_voice;
    end
  end

  // Steps and sustain above 1.0 are saturated as they are written.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_shape  <= 1'b0;
      cfg.attack_step   <= dadsr_pkg::LEVEL_ONE;
      cfg.decay_step    <= dadsr_pkg::LEVEL_ONE;
      cfg.sustain_level <= dadsr_pkg::LEVEL_ONE;
      cfg.release_step  <= dadsr_pkg::LEVEL_ONE;
      cfg.delay_ticks   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dadsr_pkg::REG_LINEAR_SHAPE:  cfg.linear_shape  <= cfg_data[0];
        dadsr_pkg::REG_ATTACK_STEP:   cfg.attack_step   <= dadsr_pkg::sat_one(cfg_data[15:0]);
        dadsr_pkg::REG_DECAY_STEP:    cfg.decay_step    <= dadsr_pkg::sat_one(cfg_data[15:0]);
        dadsr_pkg::REG_SUSTAIN_LEVEL: cfg.sustain_level <= dadsr_pkg::sat_one(cfg_data[15:0]);
        dadsr_pkg::REG_RELEASE_STEP:  cfg.release_step  <= dadsr_pkg::sat_one(cfg_data[15:0]);
        dadsr_pkg::REG_DELAY_TICKS:   cfg.delay_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign gate_ch[0]  = item.gate_left;
  assign gate_ch[1]  = item.gate_right;
  assign clear_ch[0] = item.reset_left;
  assign clear_ch[1] = item.reset_right;
  assign audio_ch[0] = item.audio_left;
  assign audio_ch[1] = item.audio_right;

  for (genvar c = 0; c < dadsr_pkg::NCH; c++) begin : g_lane
    if (c < LANES) begin : g_on
      dadsr_lane #(
        .VOICES (VOICES)
      ) u_lane (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .cfg   (cfg),
        .voice (item.voice),
        .gate  (gate_ch[c]),
        .clear (clear_ch[c]),
        .audio (audio_ch[c]),
        .res   (lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c] = '0;
    end
  end

  dadsr_merge u_merge (
    .clk    (clk),
    .load   (s2_adv),
    .voice  (s2_voice),
    .lanes  (lane_res),
    .result (result)
  );

  `DADSR_ASSERT_NOW(a_level_max, result_valid, (result.level_left <= dadsr_pkg::LEVEL_ONE) && (result.level_right <= dadsr_pkg::LEVEL_ONE), "level above 1.0")
  `DADSR_ASSERT_NEXT(a_s2_moves, s2_adv, result_valid, "update stage moved but no result followed")
  `DADSR_ASSERT_NOW(a_out_of_range, result_valid && (32'(result.voice_out) >= 32'(VOICES)), (result.level_left == '0) && (result.level_right == '0), "voice out of range produced a level")
  `DADSR_ASSERT_NOW(a_missing_lane, result_valid && (LANES < dadsr_pkg::NCH), (result.level_right == '0) && (result.shaped_right == '0), "missing channel produced output")

endmodule

### sim/delay_adsr_envelope_generator_tb.sv
`timescale 1ns / 1ps

module delay_adsr_envelope_generator_tb;

  localparam int LANES      = dadsr_pkg::DEF_VOICES * dadsr_pkg::NCH;
  localparam int FULL_LEVEL = 32768;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASES     = 8;
  localparam int PHASE_TICKS = 190;

  class envelope_scoreboard;
    dadsr_pkg::cfg_t      regs;
    logic [2:0]           seg [LANES];
    int                   lvl [LANES];
    logic [23:0]          cnt [LANES];
    bit                   held [LANES];
    dadsr_pkg::out_item_t expected_q[$];
    int                   failures;

    function new();
      regs = '{1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 24'd0};
      foreach (seg[k]) begin
        seg[k] = dadsr_pkg::SEG_RELEASE;
        lvl[k] = 0;
        cnt[k] = '0;
        held[k] = 1'b0;
      end
      failures = 0;
    endfunction

    function void write_reg(logic [dadsr_pkg::CFG_IDX_W-1:0] idx,
                            logic [dadsr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dadsr_pkg::REG_LINEAR_SHAPE:  regs.linear_shape = data[0];
        dadsr_pkg::REG_ATTACK_STEP:   regs.attack_step = data[15:0];
        dadsr_pkg::REG_DECAY_STEP:    regs.decay_step = data[15:0];
        dadsr_pkg::REG_SUSTAIN_LEVEL: regs.sustain_level = data[15:0];
        dadsr_pkg::REG_RELEASE_STEP:  regs.release_step = data[15:0];
        dadsr_pkg::REG_DELAY_TICKS:   regs.delay_ticks = data[23:0];
        default: ;
      endcase
    endfunction

    function int clip_full(int v);
      return (v > FULL_LEVEL) ? FULL_LEVEL : v;
    endfunction

    function int fall_lin(int l, int s);
      return (l > s) ? l - s : 0;
    endfunction

    // Exponential fall works on level + 1.0 so that it reaches zero in finite time.
    function int fall_exp(int l, int s);
      longint t;
      t = (longint'(l + FULL_LEVEL) * longint'(FULL_LEVEL - s)) >>> 15;
      return (t > FULL_LEVEL) ? int'(t - FULL_LEVEL) : 0;
    endfunction

    function int rise_exp(int l, int s);
      longint t;
      longint v;
      t = (longint'(2 * FULL_LEVEL - l) * longint'(FULL_LEVEL - s)) >>> 15;
      v = 2 * FULL_LEVEL - t;
      return (v > FULL_LEVEL) ? FULL_LEVEL : int'(v);
    endfunction

    function void tick_lane(int k, logic signed [15:0] gate, logic signed [15:0] clear,
                            logic signed [15:0] audio, output logic [15:0] level_o,
                            output logic signed [15:0] shaped_o);
      int     l;
      int     sus;
      int     att;
      int     dec;
      int     rel;
      bit     lin;
      longint prod;
      sus = clip_full(int'(regs.sustain_level));
      att = clip_full(int'(regs.attack_step));
      dec = clip_full(int'(regs.decay_step));
      rel = clip_full(int'(regs.release_step));
      lin = regs.linear_shape;
      if (clear >= dadsr_pkg::RESET_ON) begin
        seg[k] = dadsr_pkg::SEG_RELEASE;
        lvl[k] = 0;
        cnt[k] = '0;
        held[k] = 1'b0;
      end
      if (gate > dadsr_pkg::GATE_HIGH) begin
        if (!held[k]) begin
          cnt[k] = '0;
          seg[k] = dadsr_pkg::SEG_DELAY;
        end
        held[k] = 1'b1;
      end else if (gate <= dadsr_pkg::GATE_LOW) begin
        if (held[k]) seg[k] = dadsr_pkg::SEG_RELEASE;
        held[k] = 1'b0;
      end
      l = lvl[k];
      case (seg[k])
        dadsr_pkg::SEG_DELAY: begin
          l = lin ? fall_lin(l, rel) : fall_exp(l, rel);
          if (cnt[k] != dadsr_pkg::COUNT_MAX) cnt[k]++;
          if (cnt[k] >= regs.delay_ticks) seg[k] = dadsr_pkg::SEG_ATTACK;
        end
        dadsr_pkg::SEG_ATTACK: begin
          l = lin ? clip_full(l + att) : rise_exp(l, att);
          if (l >= FULL_LEVEL) seg[k] = dadsr_pkg::SEG_DECAY;
        end
        dadsr_pkg::SEG_DECAY: begin
          if (lin) begin
            l = fall_lin(l, dec);
          end else begin
            l = fall_exp(l, dec);
            if (l < sus) l = sus;
            if (l > FULL_LEVEL) l = FULL_LEVEL;
          end
          if (l <= sus) begin
            l = sus;
            seg[k] = dadsr_pkg::SEG_SUSTAIN;
          end
        end
        dadsr_pkg::SEG_SUSTAIN: ;
        default: l = lin ? fall_lin(l, rel) : fall_exp(l, rel);
      endcase
      lvl[k] = l;
      // An arithmetic shift floors, which is what the audio scaling needs.
      prod = longint'(audio) * longint'(l);
      shaped_o = 16'(prod >>> 15);
      level_o = 16'(l);
    endfunction

    function void note_item(dadsr_pkg::in_item_t x);
      dadsr_pkg::out_item_t e;
      e.voice_out = x.voice;
      tick_lane(2 * x.voice, x.gate_left, x.reset_left, x.audio_left,
                e.level_left, e.shaped_left);
      tick_lane(2 * x.voice + 1, x.gate_right, x.reset_right, x.audio_right,
                e.level_right, e.shaped_right);
      expected_q = {expected_q, e};
    endfunction

    function void check_result(dadsr_pkg::out_item_t got);
      dadsr_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        $error("result for voice %0d arrived with none expected", got.voice_out);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      if (got.voice_out !== e.voice_out) begin
        $error("voice_out: expected %0d, got %0d", e.voice_out, got.voice_out);
        failures++;
      end
      if (got.level_left !== e.level_left) begin
        $error("level_left: expected %0d, got %0d", e.level_left, got.level_left);
        failures++;
      end
      if (got.level_right !== e.level_right) begin
        $error("level_right: expected %0d, got %0d", e.level_right, got.level_right);
        failures++;
      end
      if (got.shaped_left !== e.shaped_left) begin
        $error("shaped_left: expected %0d, got %0d", e.shaped_left, got.shaped_left);
        failures++;
      end
      if (got.shaped_right !== e.shaped_right) begin
        $error("shaped_right: expected %0d, got %0d", e.shaped_right, got.shaped_right);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             item_valid;
  logic                             item_ready;
  dadsr_pkg::in_item_t              item;
  logic                             result_valid;
  logic                             result_ready = 1'b0;
  dadsr_pkg::out_item_t             result;
  logic                             cfg_write;
  logic [dadsr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dadsr_pkg::CFG_DATA_W-1:0] cfg_data;

  envelope_scoreboard store;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int                 quiet_cycles;
  bit                 gate_on [LANES];

  delay_adsr_envelope_generator i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) store.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic dadsr_pkg::in_item_t mk(int v, int gl, int gr, int rl, int rr,
                                              int al, int ar);
    dadsr_pkg::in_item_t x;
    x.voice = 4'(v);
    x.gate_left = 16'(gl);
    x.gate_right = 16'(gr);
    x.reset_left = 16'(rl);
    x.reset_right = 16'(rr);
    x.audio_left = 16'(al);
    x.audio_right = 16'(ar);
    return x;
  endfunction

  // Mostly clean gate levels that follow a slowly toggling intent, so that
  // envelopes run through all their segments; some values sit in the hysteresis band.
  function automatic logic signed [15:0] make_gate(bit on);
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'($urandom);
    if (r < 18) return 16'($urandom_range(5461, 2731));
    if (on) return 16'($urandom_range(32767, 5462));
    return 16'(int'($urandom_range(35498)) - 32768);
  endfunction

  function automatic logic signed [15:0] make_clear();
    if ($urandom_range(99) < 3) return 16'($urandom_range(32767, 8192));
    return 16'(int'($urandom_range(40959)) - 32768);
  endfunction

  function automatic dadsr_pkg::in_item_t next_random_tick();
    dadsr_pkg::in_item_t x;
    int                  v;
    v = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15);
    if ($urandom_range(99) < 6) gate_on[2 * v] = !gate_on[2 * v];
    if ($urandom_range(99) < 6) gate_on[2 * v + 1] = !gate_on[2 * v + 1];
    x.voice = 4'(v);
    x.gate_left = make_gate(gate_on[2 * v]);
    x.gate_right = make_gate(gate_on[2 * v + 1]);
    x.reset_left = make_clear();
    x.reset_right = make_clear();
    x.audio_left = 16'($urandom);
    x.audio_right = 16'($urandom);
    return x;
  endfunction

  function automatic dadsr_pkg::cfg_t setting_for(int p);
    dadsr_pkg::cfg_t c;
    case (p)
      0: c = '{1'b1, 16'd3000, 16'd2000, 16'd16384, 16'd1500, 24'd3};
      1: c = '{1'b0, 16'd4000, 16'd3000, 16'd20000, 16'd2500, 24'd0};
      2: c = '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0};
      3: c = '{1'b0, 16'h8000, 16'h8000, 16'd0, 16'h8000, 24'd1};
      4: c = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF};
      5: c = '{1'b0, 16'd1200, 16'd800, 16'd8000, 16'd600, 24'd5};
      6: c = '{1'b1, 16'($urandom_range(8192, 1)), 16'($urandom_range(8192, 1)),
               16'($urandom_range(32768)), 16'($urandom_range(8192, 1)),
               24'($urandom_range(8))};
      default: c = '{1'b0, 16'($urandom_range(8192)), 16'($urandom_range(8192)),
                     16'($urandom_range(32768)), 16'($urandom_range(8192)),
                     24'($urandom_range(8))};
    endcase
    return c;
  endfunction

  task automatic send_item(input dadsr_pkg::in_item_t x);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    store.note_item(x);
  endtask

  task automatic stop_items();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic drain();
    while (store.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input dadsr_pkg::cfg_t c);
    logic [dadsr_pkg::CFG_IDX_W-1:0]  idx [6];
    logic [dadsr_pkg::CFG_DATA_W-1:0] val [6];
    idx = '{dadsr_pkg::REG_LINEAR_SHAPE, dadsr_pkg::REG_ATTACK_STEP,
            dadsr_pkg::REG_DECAY_STEP, dadsr_pkg::REG_SUSTAIN_LEVEL,
            dadsr_pkg::REG_RELEASE_STEP, dadsr_pkg::REG_DELAY_TICKS};
    val = '{24'(c.linear_shape), 24'(c.attack_step), 24'(c.decay_step),
            24'(c.sustain_level), 24'(c.release_step), c.delay_ticks};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      store.write_reg(idx[i], val[i]);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    dadsr_pkg::in_item_t directed[$];
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_cycles = 0;
    send_idle_pct = 15;
    recv_idle_pct = 85;
    store = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default registers give full steps, so delay, attack and decay each last a single tick.
    directed = {directed, mk(0, 32767, 32767, -32768, -32768, 32767, -32768)};
    directed = {directed, mk(0, 5462, 5462, 0, 0, -32768, 32767)};
    directed = {directed, mk(0, 5461, 4000, 8191, 8191, 32767, -32768)};
    directed = {directed, mk(0, 2731, 2731, 0, 0, -32768, 32767)};
    directed = {directed, mk(0, 2730, 2730, 0, 0, 1, -1)};
    directed = {directed, mk(0, -32768, -32768, 0, 0, 32767, 32767)};
    directed = {directed, mk(15, 32767, -32768, 8191, 8192, -1, -1)};
    directed = {directed, mk(15, 32767, 32767, 8192, 32767, 100, -100)};
    directed = {directed, mk(15, 32767, 32767, -1, -1, 8192, -8192)};
    directed = {directed, mk(15, 32767, 32767, 0, 0, -8192, 8192)};
    directed = {directed, mk(15, 32767, 32767, 32767, 0, 32767, -32768)};
    directed = {directed, mk(15, 0, 0, 0, 0, 0, 0)};
    directed = {directed, mk(7, 6000, 6000, 0, 0, 12345, -12345)};
    directed = {directed, mk(7, 3000, 3000, 0, 0, -12345, 12345)};
    directed = {directed, mk(7, 6000, 6000, 0, 0, 21845, -21846)};
    directed = {directed, mk(7, 6000, 6000, 0, 0, -1, 1)};
    directed = {directed, mk(7, 2730, 2730, 0, 0, 4096, -4096)};
    directed = {directed, mk(7, 32767, 2730, 0, 0, 32767, -32768)};
    directed = {directed, mk(8, 32767, 32767, 0, 0, -32768, -32768)};
    directed = {directed, mk(8, 32767, 32767, 32767, 32767, -32768, -32768)};
    foreach (directed[i]) send_item(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      stop_items();
      drain();
      apply_setting(setting_for(p));
      if (p < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 85;
      end else if (p < 6) begin
        send_idle_pct = 85;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // Halfway through one phase the sender holds off until the pipeline is empty.
        if (p == 4 && n == PHASE_TICKS / 2) begin
          stop_items();
          drain();
        end
        send_item(next_random_tick());
      end
    end

    stop_items();
    drain();
    repeat (8) @(posedge clk);
    if (store.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
